>>> sv/mecm_pkg.sv
package mecm_pkg;

    localparam int DataWidth         = 32;
    localparam int FracBits          = 16;
    localparam int QueueDepthDefault = 2;
    localparam int CfgIndexWidth     = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_ABS_LIMIT = CfgIndexWidth'(0);
    localparam logic [CfgIndexWidth-1:0] CFG_REL_LIMIT = CfgIndexWidth'(1);

    localparam logic [DataWidth-1:0] SatValue = {DataWidth{1'b1}};

    // one classified pair on its way from the front to the back
    typedef struct packed {
        logic [DataWidth-1:0] abs_err;
        logic [DataWidth-1:0] old_mag;
        logic                 last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_APPLY
    } bk_state_t;

endpackage

>>> sv/mecm_front.sv
module mecm_front
    import mecm_pkg::*;
(
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DataWidth-1:0] new_value,
    input  logic signed [DataWidth-1:0] old_value,
    input  logic                        last,
    input  q_status_t                   q_status,
    output logic                        q_push,
    output q_entry_t                    q_wdata
);

    logic signed [DataWidth:0] diff;
    logic        [DataWidth:0] diff_mag;

    always_comb
    begin
        diff     = {new_value[DataWidth-1], new_value} - {old_value[DataWidth-1], old_value};
        diff_mag = diff[DataWidth] ? (~diff + 1'b1) : diff;
        // magnitude of a 33-bit difference never exceeds 2^32 - 1
        q_wdata.abs_err = diff_mag[DataWidth-1:0];
        q_wdata.old_mag = old_value[DataWidth-1] ? (~old_value + 1'b1) : old_value;
        q_wdata.last    = last;
    end

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full;

endmodule

>>> sv/mecm_fifo.sv
module mecm_fifo
    import mecm_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  wdata,
    input  logic      pop,
    output q_entry_t  rdata,
    output q_status_t status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    q_entry_t            mem [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CntW'(DEPTH));
    assign status.empty = (count_reg == '0);

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");
`endif

endmodule

>>> sv/mecm_back.sv
module mecm_back
    import mecm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_status_t            q_status,
    input  q_entry_t             q_rdata,
    output logic                 q_pop,
    input  logic [DataWidth-1:0] abs_limit,
    input  logic [DataWidth-1:0] rel_limit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DataWidth-1:0] max_abs_error,
    output logic [DataWidth-1:0] max_rel_error,
    output logic                 converged
);

    localparam int CntW = $clog2(DataWidth);
    localparam int HiW  = DataWidth - FracBits;

    bk_state_t            state_reg, state_next;
    logic [DataWidth-1:0] abs_reg,   abs_next;
    logic [DataWidth-1:0] omag_reg,  omag_next;
    logic                 last_reg,  last_next;
    logic [DataWidth-1:0] rem_reg,   rem_next;
    logic [DataWidth-1:0] quo_reg,   quo_next;
    logic [CntW-1:0]      cnt_reg,   cnt_next;
    logic [DataWidth-1:0] run_abs_reg, run_abs_next;
    logic [DataWidth-1:0] run_rel_reg, run_rel_next;
    logic                 ov_reg,    ov_next;
    logic [DataWidth-1:0] oabs_reg,  oabs_next;
    logic [DataWidth-1:0] orel_reg,  orel_next;
    logic                 oconv_reg, oconv_next;

    logic [DataWidth:0]   rem_sh;
    logic                 rem_ge;
    logic [DataWidth:0]   rem_sub;
    logic [DataWidth-1:0] cand_abs;
    logic [DataWidth-1:0] cand_rel;
    logic                 out_blocked;

    always_comb
    begin
        rem_sh      = {rem_reg, quo_reg[DataWidth-1]};
        rem_ge      = (rem_sh >= {1'b0, omag_reg});
        rem_sub     = rem_sh - {1'b0, omag_reg};
        cand_abs    = (abs_reg > run_abs_reg) ? abs_reg : run_abs_reg;
        cand_rel    = (quo_reg > run_rel_reg) ? quo_reg : run_rel_reg;
        out_blocked = ov_reg && out_stall;

        state_next   = state_reg;
        abs_next     = abs_reg;
        omag_next    = omag_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        run_abs_next = run_abs_reg;
        run_rel_next = run_rel_reg;
        ov_next      = ov_reg && out_stall;
        oabs_next    = oabs_reg;
        orel_next    = orel_reg;
        oconv_next   = oconv_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop     = 1'b1;
                    abs_next  = q_rdata.abs_err;
                    omag_next = q_rdata.old_mag;
                    last_next = q_rdata.last;
                    // upper dividend bits seed the remainder; lower ones shift in
                    rem_next  = DataWidth'(q_rdata.abs_err[DataWidth-1:FracBits]);
                    quo_next  = {q_rdata.abs_err[FracBits-1:0], {FracBits{1'b0}}};
                    cnt_next  = '0;
                    if (q_rdata.old_mag == '0)
                    begin
                        quo_next   = '0;
                        state_next = BK_APPLY;
                    end
                    else if (DataWidth'(q_rdata.abs_err[DataWidth-1:DataWidth-HiW])
                             >= q_rdata.old_mag)
                    begin
                        // quotient reaches 2^32: saturate
                        quo_next   = SatValue;
                        state_next = BK_APPLY;
                    end
                    else
                    begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next = rem_ge ? rem_sub[DataWidth-1:0] : rem_sh[DataWidth-1:0];
                quo_next = {quo_reg[DataWidth-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DataWidth - 1))
                begin
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                if (!(last_reg && out_blocked))
                begin
                    state_next = BK_IDLE;
                    if (last_reg)
                    begin
                        ov_next      = 1'b1;
                        oabs_next    = cand_abs;
                        orel_next    = cand_rel;
                        oconv_next   = (cand_abs <= abs_limit) || (cand_rel <= rel_limit);
                        run_abs_next = '0;
                        run_rel_next = '0;
                    end
                    else
                    begin
                        run_abs_next = cand_abs;
                        run_rel_next = cand_rel;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            run_abs_reg <= '0;
            run_rel_reg <= '0;
            ov_reg      <= 1'b0;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            run_abs_reg <= run_abs_next;
            run_rel_reg <= run_rel_next;
            ov_reg      <= ov_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg   <= abs_next;
        omag_reg  <= omag_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        oabs_reg  <= oabs_next;
        orel_reg  <= orel_next;
        oconv_reg <= oconv_next;
    end

    assign out_valid     = ov_reg;
    assign max_abs_error = oabs_reg;
    assign max_rel_error = orel_reg;
    assign converged     = oconv_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (omag_reg != '0))
        else $error("divide entered with zero divisor");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (rem_reg < omag_reg))
        else $error("partial remainder out of range");
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_APPLY && last_reg && !out_blocked) |=> out_valid)
        else $error("sweep result not loaded");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE))
        else $error("queue read while busy");
`endif

endmodule

>>> sv/max_error_convergence_monitor.sv
// Max-error convergence monitor.
// Input channel (in_valid / in_stall): one new/old pair of signed Q16.16 values
// per transfer, with last marking the final pair of a sweep. Output channel
// (out_valid / out_stall): one transfer per sweep carrying the running maxima
// of absolute and relative error and the converged flag.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 writes
// abs_limit, index 1 writes rel_limit. Write only while the block is idle.
// A front stage forms |new - old| and |old| and queues the pair; the back end
// runs a restoring divider at one quotient bit per cycle. A pair with nonzero
// old value and an unsaturated quotient passes through the back end as pop,
// 32 divide steps and update; a zero old value or a saturated quotient goes
// from pop straight to update. The sweep result is visible the cycle after
// the update of its last pair. The queue absorbs input while the divider is busy.
// When out_stall holds a result, the back end waits at the next last pair;
// the queue then fills and in_stall rises.
// Reset clears the limits, the running maxima, the queue and out_valid.
module max_error_convergence_monitor
    import mecm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DataWidth-1:0] new_value,
    input  logic signed [DataWidth-1:0] old_value,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic        [DataWidth-1:0] max_abs_error,
    output logic        [DataWidth-1:0] max_rel_error,
    output logic                        converged,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic    [CfgIndexWidth-1:0] cfg_index,
    input  logic        [DataWidth-1:0] cfg_data
);

    logic [DataWidth-1:0] abs_limit_reg, abs_limit_next;
    logic [DataWidth-1:0] rel_limit_reg, rel_limit_next;

    q_status_t q_status;
    q_entry_t  q_wdata;
    q_entry_t  q_rdata;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        abs_limit_next = abs_limit_reg;
        rel_limit_next = rel_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ABS_LIMIT: abs_limit_next = cfg_data;
                CFG_REL_LIMIT: rel_limit_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_limit_reg <= '0;
            rel_limit_reg <= '0;
        end
        else
        begin
            abs_limit_reg <= abs_limit_next;
            rel_limit_reg <= rel_limit_next;
        end
    end

    mecm_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .new_value (new_value),
        .old_value (old_value),
        .last      (last),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    mecm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    mecm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .abs_limit     (abs_limit_reg),
        .rel_limit     (rel_limit_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_abs_error (max_abs_error),
        .max_rel_error (max_rel_error),
        .converged     (converged)
    );

endmodule

>>> bench/mecm_checker.sv
module mecm_checker
    import mecm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [DataWidth-1:0]     new_value,
    input  logic [DataWidth-1:0]     old_value,
    input  logic                     last,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [DataWidth-1:0]     max_abs_error,
    input  logic [DataWidth-1:0]     max_rel_error,
    input  logic                     converged,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [DataWidth-1:0]     cfg_data,
    output int                       mismatches,
    output int                       sweeps_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DataWidth-1:0] abs_err;
        logic [DataWidth-1:0] rel_err;
    } pair_err_t;

    typedef struct packed {
        logic [DataWidth-1:0] max_abs;
        logic [DataWidth-1:0] max_rel;
        logic                 conv;
    } sweep_report_t;

    logic [DataWidth-1:0] abs_limit_q;
    logic [DataWidth-1:0] rel_limit_q;
    logic [DataWidth-1:0] peak_abs;
    logic [DataWidth-1:0] peak_rel;
    sweep_report_t        sweep_reports_q[$];
    int                   reports_issued;
    int                   reports_seen;

    assign sweeps_pending = reports_issued - reports_seen;

    // |new - old| and |new - old| / |old| in Q16.16, both clamped to 32 bits
    function automatic pair_err_t pair_errors(logic [DataWidth-1:0] nv,
                                              logic [DataWidth-1:0] ov);
        longint          diff;
        longint          ov_s;
        longint unsigned old_mag;
        longint unsigned quo;
        pair_err_t       res;
        diff = longint'($signed(nv)) - longint'($signed(ov));
        if (diff < 0)
            diff = -diff;
        res.abs_err = (diff > 64'hFFFF_FFFF) ? SatValue : diff[31:0];
        ov_s = longint'($signed(ov));
        old_mag = (ov_s < 0) ? longint'(-ov_s) : ov_s;
        if (old_mag == 0)
        begin
            res.rel_err = '0;
        end
        else
        begin
            quo = {16'h0, res.abs_err, 16'h0} / old_mag;
            res.rel_err = (quo > 64'hFFFF_FFFF) ? SatValue : quo[31:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_err_t     errs;
        sweep_report_t exp_rep;
        if (!rst_n)
        begin
            abs_limit_q    = '0;
            rel_limit_q    = '0;
            peak_abs       = '0;
            peak_rel       = '0;
            mismatches     = 0;
            reports_issued = 0;
            reports_seen   = 0;
            sweep_reports_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ABS_LIMIT)
                    abs_limit_q = cfg_data;
                else if (cfg_index == CFG_REL_LIMIT)
                    rel_limit_q = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                errs = pair_errors(new_value, old_value);
                if (errs.abs_err > peak_abs)
                    peak_abs = errs.abs_err;
                if (errs.rel_err > peak_rel)
                    peak_rel = errs.rel_err;
                if (last)
                begin
                    exp_rep.max_abs = peak_abs;
                    exp_rep.max_rel = peak_rel;
                    exp_rep.conv    = (peak_abs <= abs_limit_q) || (peak_rel <= rel_limit_q);
                    sweep_reports_q.push_back(exp_rep);
                    reports_issued++;
                    peak_abs = '0;
                    peak_rel = '0;
                end
            end

            if (out_valid && !out_stall)
            begin
                if (sweep_reports_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: abs %h rel %h conv %b",
                             $time, max_abs_error, max_rel_error, converged);
                    mismatches++;
                end
                else
                begin
                    exp_rep = sweep_reports_q.pop_front();
                    reports_seen++;
                    if (max_abs_error !== exp_rep.max_abs)
                    begin
                        $display("%0t: max_abs_error expected %h, actual %h",
                                 $time, exp_rep.max_abs, max_abs_error);
                        mismatches++;
                    end
                    if (max_rel_error !== exp_rep.max_rel)
                    begin
                        $display("%0t: max_rel_error expected %h, actual %h",
                                 $time, exp_rep.max_rel, max_rel_error);
                        mismatches++;
                    end
                    if (converged !== exp_rep.conv)
                    begin
                        $display("%0t: converged expected %b, actual %b",
                                 $time, exp_rep.conv, converged);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mecm_pkg::*;

    localparam int SettleCycles = 200;
    localparam int SegmentItems = 387;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [DataWidth-1:0] new_value;
    logic signed [DataWidth-1:0] old_value;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic        [DataWidth-1:0] max_abs_error;
    logic        [DataWidth-1:0] max_rel_error;
    logic                        converged;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic    [CfgIndexWidth-1:0] cfg_index;
    logic        [DataWidth-1:0] cfg_data;

    int mismatches;
    int sweeps_pending;
    int in_idle_pct   = 13;
    int out_stall_pct = 71;

    max_error_convergence_monitor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .new_value     (new_value),
        .old_value     (old_value),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_abs_error (max_abs_error),
        .max_rel_error (max_rel_error),
        .converged     (converged),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mecm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .new_value      (new_value),
        .old_value      (old_value),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .max_abs_error  (max_abs_error),
        .max_rel_error  (max_rel_error),
        .converged      (converged),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .sweeps_pending (sweeps_pending)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    initial
    begin
        #4_800_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_pair(input logic [DataWidth-1:0] nv, input logic [DataWidth-1:0] ov,
                             input logic lst);
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        new_value <= nv;
        old_value <= ov;
        last      <= lst;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [DataWidth-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every sweep report, then let trailing pairs retire
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (sweeps_pending == 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [DataWidth-1:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic void gen_pair(input bit quiet, output logic [DataWidth-1:0] nv,
                                     output logic [DataWidth-1:0] ov);
        int mode;
        mode = (quiet && $urandom_range(0, 99) < 85) ? 4 : $urandom_range(0, 4);
        case (mode)
            0:
            begin
                nv = $urandom();
                ov = $urandom();
            end
            1:
            begin
                nv = $urandom();
                ov = '0;
            end
            2:
            begin
                nv = corner_value();
                ov = corner_value();
            end
            3:
            begin
                nv = $urandom();
                ov = $urandom_range(1, 255);
                if ($urandom_range(0, 1))
                    ov = -ov;
            end
            default:
            begin
                ov = $urandom();
                nv = ov + $urandom_range(0, 32'h4000) - 32'h2000;
            end
        endcase
    endfunction

    task automatic send_sweep(input bit quiet, input int len);
        logic [DataWidth-1:0] nv;
        logic [DataWidth-1:0] ov;
        for (int i = 0; i < len; i++)
        begin
            gen_pair(quiet, nv, ov);
            send_pair(nv, ov, i == len - 1);
        end
    endtask

    task automatic run_segment(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            // mostly short sweeps; now and then a long one
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_sweep($urandom_range(0, 99) < 60, len);
            sent += len;
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        new_value = '0;
        old_value = '0;
        last      = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ABS_LIMIT;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_ABS_LIMIT, 32'h0000_0000);
        write_reg(CFG_REL_LIMIT, 32'h0000_0000);

        // zero pair on its own, then the widest differences both ways
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // multi-pair sweep ending on a zero old value
        send_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_pair(32'h0003_0000, 32'h0001_0000, 1'b0);
        send_pair(32'h0000_0005, 32'h0000_0000, 1'b1);
        // quotient truncation, sign handling, most negative old value
        send_pair(32'h0000_0007, 32'h0000_0003, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        send_pair(32'h0000_0000, 32'h8000_0000, 1'b1);
        // relative error just below and just above saturation
        send_pair(32'h0001_0000, 32'h0000_0001, 1'b1);
        send_pair(32'h0001_0001, 32'h0000_0001, 1'b1);
        send_pair(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1);
        // tiny difference on a huge old value gives zero relative error
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1);
        send_pair(32'h8000_0001, 32'h8000_0000, 1'b1);

        for (int seg = 0; seg < 5; seg++)
        begin
            settle();
            in_idle_pct   = (seg < 2) ? 13 : (seg < 4) ? 71 : 0;
            out_stall_pct = (seg < 2) ? 71 : (seg < 4) ? 13 : 0;
            case (seg)
                1:
                begin
                    write_reg(CFG_ABS_LIMIT, 32'hFFFF_FFFF);
                    write_reg(CFG_REL_LIMIT, 32'h0000_0000);
                end
                3:
                begin
                    write_reg(CFG_ABS_LIMIT, 32'h0000_0000);
                    write_reg(CFG_REL_LIMIT, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(CFG_ABS_LIMIT, $urandom_range(0, 32'h0004_0000));
                    write_reg(CFG_REL_LIMIT, $urandom_range(0, 32'h0002_0000));
                end
            endcase
            run_segment(SegmentItems);
        end

        settle();
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
